### src/ppe_pkg.sv
// shared codes and result type for the page programming engine
package ppe_pkg;

  // event kinds on the input stream
  localparam logic [2:0] KIND_WR_START = 3'd0;
  localparam logic [2:0] KIND_RX_BYTE  = 3'd1;
  localparam logic [2:0] KIND_RD_START = 3'd2;
  localparam logic [2:0] KIND_TX_REQ   = 3'd3;
  localparam logic [2:0] KIND_STOP_WR  = 3'd4;
  localparam logic [2:0] KIND_STOP_RD  = 3'd5;

  // command bytes
  localparam logic [7:0] CMD_NONE    = 8'h00;
  localparam logic [7:0] CMD_APPEND  = 8'h01;
  localparam logic [7:0] CMD_PROGRAM = 8'h02;
  localparam logic [7:0] CMD_FETCH   = 8'h03;
  localparam logic [7:0] CMD_REWIND  = 8'h04;
  localparam logic [7:0] CMD_RESTART = 8'h05;

  // bus responses
  localparam logic [1:0] RESP_RESPOND     = 2'd0;
  localparam logic [1:0] RESP_ACK_RESPOND = 2'd1;
  localparam logic [1:0] RESP_COMPLETE    = 2'd2;
  localparam logic [1:0] RESP_NONE        = 2'd3;

  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [1:0] bus_response;
    logic       reset_request;
  } ppe_res_t;

endpackage

### src/ppe_buf.sv
// page buffer memory with per-entry valid bits, registered read
module ppe_buf #(
  parameter int PAGE_BYTES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [$clog2(PAGE_BYTES)-1:0] waddr_i,
  input  logic [7:0]                    wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(PAGE_BYTES)-1:0] raddr_i,
  output logic [7:0]                    rdata_o
);

  logic [7:0]            mem [PAGE_BYTES];
  logic [PAGE_BYTES-1:0] valid_q;
  logic [7:0]            rd_q;
  logic                  rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_valid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_valid_q ? rd_q : 8'h00;

endmodule

### src/ppe_flash.sv
// flash page store with per-page programmed bits, registered read
module ppe_flash #(
  parameter int PAGE_BYTES = 64,
  parameter int PAGE_COUNT = 256,
  localparam int Depth = PAGE_BYTES * PAGE_COUNT,
  localparam int FaW   = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int PgW   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           we_i,
  input  logic [FaW-1:0] waddr_i,
  input  logic [7:0]     wdata_i,
  input  logic           re_i,
  input  logic [FaW-1:0] raddr_i,
  input  logic [PgW-1:0] page_i,
  input  logic           mark_i,
  output logic [7:0]     rdata_o
);

  logic [7:0]            mem [Depth];
  logic [PAGE_COUNT-1:0] prog_q;
  logic [7:0]            rd_q;
  logic                  rd_prog_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
    end
  end

  // pages never programmed read as erased
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q    <= '0;
      rd_prog_q <= 1'b0;
    end else begin
      if (mark_i) begin
        prog_q[page_i] <= 1'b1;
      end
      if (re_i) begin
        rd_prog_q <= prog_q[page_i];
      end
    end
  end

  assign rdata_o = rd_prog_q ? rd_q : ppe_pkg::ERASED_BYTE;

endmodule

### src/ppe_seq.sv
// event sequencer: command decode, page number reduction and page copy loop
module ppe_seq #(
  parameter int PAGE_BYTES = 64,
  parameter int PAGE_COUNT = 256,
  localparam int BiW   = $clog2(PAGE_BYTES),
  localparam int Depth = PAGE_BYTES * PAGE_COUNT,
  localparam int FaW   = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int PgW   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [2:0]       kind_i,
  input  logic [7:0]       rx_byte_i,
  output logic             idle_o,
  output ppe_pkg::ppe_res_t res_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  // page buffer port
  output logic             buf_we_o,
  output logic [BiW-1:0]   buf_waddr_o,
  output logic [7:0]       buf_wdata_o,
  output logic             buf_re_o,
  output logic [BiW-1:0]   buf_raddr_o,
  input  logic [7:0]       buf_rdata_i,
  // flash port
  output logic             fl_we_o,
  output logic [FaW-1:0]   fl_waddr_o,
  output logic [7:0]       fl_wdata_o,
  output logic             fl_re_o,
  output logic [FaW-1:0]   fl_raddr_o,
  output logic [PgW-1:0]   fl_page_o,
  output logic             fl_mark_o,
  input  logic [7:0]       fl_rdata_i
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_TXWAIT = 3'd2;
  localparam logic [2:0] ST_MOD    = 3'd3;
  localparam logic [2:0] ST_BASE   = 3'd4;
  localparam logic [2:0] ST_COPY   = 3'd5;
  localparam logic [2:0] ST_DRAIN  = 3'd6;
  localparam logic [2:0] ST_FIN    = 3'd7;

  localparam logic [BiW-1:0] LastIdx = BiW'(PAGE_BYTES - 1);
  // ceil(2^16 / PAGE_COUNT), exact quotient for every 8-bit argument
  localparam logic [16:0]    RecipMul = 17'((65536 + PAGE_COUNT - 1) / PAGE_COUNT);

  logic [2:0]        state_q, state_d;
  logic [2:0]        kind_q;
  logic [7:0]        rx_q;
  logic [7:0]        cmd_q, cmd_d;
  logic [7:0]        arg_q, arg_d;
  logic [BiW-1:0]    idx_q, idx_d, idx_nxt;
  logic [7:0]        rem_q, rem_d;
  logic [2:0]        k_q, k_d;
  logic [7:0]        quot_q, quot_d;
  logic [23:0]       recip_prod;
  logic [15:0]       quot_mul;
  logic [FaW-1:0]    base_q, base_d;
  logic [BiW-1:0]    off_q, off_d;
  logic              wr_pend_q, wr_pend_d;
  logic [BiW-1:0]    wr_off_q, wr_off_d;
  logic              fetch_q, fetch_d;
  ppe_pkg::ppe_res_t res_q, res_d;
  logic [PgW-1:0]    page;

  assign idx_nxt    = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
  assign recip_prod = 24'(rem_q) * 24'(RecipMul);
  assign quot_mul   = 16'(quot_q) * 16'(PAGE_COUNT);
  assign page       = rem_q[PgW-1:0];

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    arg_d     = arg_q;
    idx_d     = idx_q;
    rem_d     = rem_q;
    k_d       = k_q;
    quot_d    = quot_q;
    base_d    = base_q;
    off_d     = off_q;
    wr_pend_d = 1'b0;
    wr_off_d  = off_q;
    fetch_d   = fetch_q;
    res_d     = res_q;

    buf_we_o    = 1'b0;
    buf_waddr_o = idx_q;
    buf_wdata_o = rx_q;
    buf_re_o    = 1'b0;
    buf_raddr_o = idx_q;
    fl_we_o     = 1'b0;
    fl_waddr_o  = base_q + FaW'(wr_off_q);
    fl_wdata_o  = buf_rdata_i;
    fl_re_o     = 1'b0;
    fl_raddr_o  = base_q + FaW'(off_q);
    fl_page_o   = page;
    fl_mark_o   = 1'b0;

    // write half of the copy loop, in the cycle after the read
    if (wr_pend_q) begin
      if (fetch_q) begin
        buf_we_o    = 1'b1;
        buf_waddr_o = wr_off_q;
        buf_wdata_o = fl_rdata_i;
      end else begin
        fl_we_o = 1'b1;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_d   = '{tx_byte: 8'h00, tx_valid: 1'b0,
                    bus_response: ppe_pkg::RESP_NONE, reset_request: 1'b0};
        state_d = ST_FIN;
        unique case (kind_q)
          ppe_pkg::KIND_WR_START: begin
            cmd_d              = ppe_pkg::CMD_NONE;
            res_d.bus_response = ppe_pkg::RESP_RESPOND;
          end
          ppe_pkg::KIND_RX_BYTE: begin
            res_d.bus_response = ppe_pkg::RESP_RESPOND;
            if (cmd_q == ppe_pkg::CMD_NONE) begin
              cmd_d = rx_q;
            end else if (cmd_q == ppe_pkg::CMD_APPEND) begin
              buf_we_o = 1'b1;
              idx_d    = idx_nxt;
            end else begin
              arg_d = rx_q;
            end
          end
          ppe_pkg::KIND_RD_START: begin
            res_d.bus_response = ppe_pkg::RESP_ACK_RESPOND;
          end
          ppe_pkg::KIND_TX_REQ: begin
            res_d.bus_response = ppe_pkg::RESP_RESPOND;
            res_d.tx_valid     = 1'b1;
            buf_re_o           = 1'b1;
            idx_d              = idx_nxt;
            state_d            = ST_TXWAIT;
          end
          ppe_pkg::KIND_STOP_WR: begin
            res_d.bus_response = ppe_pkg::RESP_COMPLETE;
            if (cmd_q == ppe_pkg::CMD_PROGRAM || cmd_q == ppe_pkg::CMD_FETCH) begin
              fetch_d = (cmd_q == ppe_pkg::CMD_FETCH);
              rem_d   = arg_q;
              k_d     = 3'd1;
              state_d = ST_MOD;
            end else if (cmd_q == ppe_pkg::CMD_REWIND) begin
              idx_d = '0;
            end else if (cmd_q == ppe_pkg::CMD_RESTART) begin
              res_d.reset_request = 1'b1;
            end
          end
          ppe_pkg::KIND_STOP_RD: begin
            res_d.bus_response = ppe_pkg::RESP_COMPLETE;
          end
          default: begin
            res_d.bus_response = ppe_pkg::RESP_NONE;
          end
        endcase
      end
      ST_TXWAIT: begin
        res_d.tx_byte = buf_rdata_i;
        state_d       = ST_FIN;
      end
      ST_MOD: begin
        // quotient by reciprocal multiply, then remainder by one subtract
        if (k_q != 3'd0) begin
          quot_d = recip_prod[23:16];
          k_d    = k_q - 3'd1;
        end else begin
          rem_d   = rem_q - quot_mul[7:0];
          state_d = ST_BASE;
        end
      end
      ST_BASE: begin
        base_d    = FaW'(page * PAGE_BYTES);
        off_d     = '0;
        fl_mark_o = !fetch_q;
        state_d   = ST_COPY;
      end
      ST_COPY: begin
        if (fetch_q) begin
          fl_re_o = 1'b1;
        end else begin
          buf_re_o    = 1'b1;
          buf_raddr_o = off_q;
        end
        wr_pend_d = 1'b1;
        off_d     = off_q + 1'b1;
        if (off_q == LastIdx) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (fetch_q) begin
          idx_d = '0;
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cmd_q     <= ppe_pkg::CMD_NONE;
      arg_q     <= 8'h00;
      idx_q     <= '0;
      wr_pend_q <= 1'b0;
      fetch_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmd_q     <= cmd_d;
      arg_q     <= arg_d;
      idx_q     <= idx_d;
      wr_pend_q <= wr_pend_d;
      fetch_q   <= fetch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == ST_IDLE) begin
      kind_q <= kind_i;
      rx_q   <= rx_byte_i;
    end
    rem_q    <= rem_d;
    k_q      <= k_d;
    quot_q   <= quot_d;
    base_q   <= base_d;
    off_q    <= off_d;
    wr_off_q <= wr_off_d;
    res_q    <= res_d;
  end

  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_FIN);
  assign res_o       = res_q;

  a_wr_after_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> $past(state_q) == ST_COPY)
    else $error("copy write without a preceding copy read");

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == ST_IDLE)
    else $error("transfer started while busy");

  a_tx_only_for_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_q.tx_valid) |-> kind_q == ppe_pkg::KIND_TX_REQ)
    else $error("tx byte flagged for a non request event");

  a_rst_on_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_q.reset_request) |->
      (res_q.bus_response == ppe_pkg::RESP_COMPLETE && cmd_q == ppe_pkg::CMD_RESTART))
    else $error("reset request outside a restart stop");

endmodule

### src/i2c_page_programming_engine_core.sv
// top level of the i2c page programming engine: stream ports and result register
//
// usage: each slave-side transfer carries one bus event, tuser = kind, tdata = received byte.
// each event yields exactly one master-side transfer with the response for the bus.
// the block takes one event at a time: s_axis_tready_o is high only while the
// sequencer is idle. a byte request adds a registered page buffer read before
// its result is ready; a new event is taken only once the last result has been
// handed to the output register.
// a stop after write with a program or fetch command first reduces the page
// number by a reciprocal multiply and a subtract, then moves one byte per cycle
// between page buffer and flash, each over one read port and one write port.
// the result sits in an output register; while the receiver stalls, the next
// event is still accepted and worked on, and its result waits until the
// register is free.
// reset clears the command, argument and index; the page buffer reads as zeros
// and the flash as erased (0xFF) until written, with no clearing pass.
module i2c_page_programming_engine_core #(
  parameter int PAGE_BYTES = 64,
  parameter int PAGE_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] tx_byte, [9:8] bus_response, [10] reset_request
  output logic [0:0]  m_axis_tuser_o    // [0] tx_valid
);

  localparam int BiW   = $clog2(PAGE_BYTES);
  localparam int Depth = PAGE_BYTES * PAGE_COUNT;
  localparam int FaW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int PgW   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  logic              idle;
  logic              start;
  ppe_pkg::ppe_res_t res;
  logic              res_valid;
  logic              res_ready;
  ppe_pkg::ppe_res_t out_q;
  logic              out_vld_q;

  logic           buf_we, buf_re;
  logic [BiW-1:0] buf_waddr, buf_raddr;
  logic [7:0]     buf_wdata, buf_rdata;
  logic           fl_we, fl_re, fl_mark;
  logic [FaW-1:0] fl_waddr, fl_raddr;
  logic [PgW-1:0] fl_page;
  logic [7:0]     fl_wdata, fl_rdata;

  assign s_axis_tready_o = idle;
  assign start           = s_axis_tvalid_i && idle;
  assign res_ready       = !out_vld_q || m_axis_tready_i;

  ppe_seq #(
    .PAGE_BYTES(PAGE_BYTES),
    .PAGE_COUNT(PAGE_COUNT)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .kind_i      (s_axis_tuser_i),
    .rx_byte_i   (s_axis_tdata_i),
    .idle_o      (idle),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .buf_we_o    (buf_we),
    .buf_waddr_o (buf_waddr),
    .buf_wdata_o (buf_wdata),
    .buf_re_o    (buf_re),
    .buf_raddr_o (buf_raddr),
    .buf_rdata_i (buf_rdata),
    .fl_we_o     (fl_we),
    .fl_waddr_o  (fl_waddr),
    .fl_wdata_o  (fl_wdata),
    .fl_re_o     (fl_re),
    .fl_raddr_o  (fl_raddr),
    .fl_page_o   (fl_page),
    .fl_mark_o   (fl_mark),
    .fl_rdata_i  (fl_rdata)
  );

  ppe_buf #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .re_i    (buf_re),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  ppe_flash #(
    .PAGE_BYTES(PAGE_BYTES),
    .PAGE_COUNT(PAGE_COUNT)
  ) u_flash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (fl_we),
    .waddr_i (fl_waddr),
    .wdata_i (fl_wdata),
    .re_i    (fl_re),
    .raddr_i (fl_raddr),
    .page_i  (fl_page),
    .mark_i  (fl_mark),
    .rdata_o (fl_rdata)
  );

  // output register, loaded when the previous result has left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'b00000, out_q.reset_request, out_q.bus_response, out_q.tx_byte};
  assign m_axis_tuser_o  = out_q.tx_valid;

endmodule

### test/i2c_page_programming_engine_core_test.sv
// testbench for the i2c page programming engine core: directed and random bus events
`timescale 1ns / 100ps

module i2c_page_programming_engine_core_test;

  localparam int PAGE_BYTES = 64;
  localparam int PAGE_COUNT = 256;

  // kinds the engine treats as no action
  localparam logic [2:0] KIND_ERROR  = 3'd6;
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic [2:0]  s_axis_tuser_i = ppe_pkg::KIND_WR_START;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;

  i2c_page_programming_engine_core #(
    .PAGE_BYTES(PAGE_BYTES),
    .PAGE_COUNT(PAGE_COUNT)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .s_axis_tuser_i(s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o),
    .m_axis_tuser_o(m_axis_tuser_o)
  );

  // engine state as the testbench sees it
  logic [7:0]  cmd_model;
  logic [7:0]  arg_model;
  int unsigned buf_pos;
  logic [7:0]  page_model [PAGE_BYTES];
  logic [7:0]  flash_model [PAGE_BYTES*PAGE_COUNT];

  ppe_pkg::ppe_res_t expected_responses [$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned events_sent;
  int unsigned responses_seen;
  int unsigned mismatches;
  int unsigned unexpected;
  int unsigned pages_programmed;
  int unsigned pages_fetched;
  int unsigned bytes_read;

  logic [7:0]  favorite_pages [4] = '{8'h00, 8'h01, 8'h80, 8'hFF};

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // response of the engine to one bus event, updating the mirrored state
  function automatic ppe_pkg::ppe_res_t bus_event_response(input logic [2:0] kind,
                                                           input logic [7:0] rx);
    ppe_pkg::ppe_res_t r;
    int unsigned       base;
    r = '0;
    r.bus_response = ppe_pkg::RESP_NONE;
    base = (int'(arg_model) % PAGE_COUNT) * PAGE_BYTES;
    case (kind)
      ppe_pkg::KIND_WR_START: begin
        cmd_model = ppe_pkg::CMD_NONE;
        r.bus_response = ppe_pkg::RESP_RESPOND;
      end
      ppe_pkg::KIND_RX_BYTE: begin
        if (cmd_model == ppe_pkg::CMD_NONE) begin
          cmd_model = rx;
        end else if (cmd_model == ppe_pkg::CMD_APPEND) begin
          page_model[buf_pos] = rx;
          buf_pos = (buf_pos + 1) % PAGE_BYTES;
        end else begin
          arg_model = rx;
        end
        r.bus_response = ppe_pkg::RESP_RESPOND;
      end
      ppe_pkg::KIND_RD_START: begin
        r.bus_response = ppe_pkg::RESP_ACK_RESPOND;
      end
      ppe_pkg::KIND_TX_REQ: begin
        r.tx_byte = page_model[buf_pos];
        r.tx_valid = 1'b1;
        buf_pos = (buf_pos + 1) % PAGE_BYTES;
        r.bus_response = ppe_pkg::RESP_RESPOND;
        bytes_read++;
      end
      ppe_pkg::KIND_STOP_WR: begin
        r.bus_response = ppe_pkg::RESP_COMPLETE;
        case (cmd_model)
          ppe_pkg::CMD_PROGRAM: begin
            for (int i = 0; i < PAGE_BYTES; i++) flash_model[base + i] = page_model[i];
            pages_programmed++;
          end
          ppe_pkg::CMD_FETCH: begin
            for (int i = 0; i < PAGE_BYTES; i++) page_model[i] = flash_model[base + i];
            buf_pos = 0;
            pages_fetched++;
          end
          ppe_pkg::CMD_REWIND: begin
            buf_pos = 0;
          end
          ppe_pkg::CMD_RESTART: begin
            r.reset_request = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ppe_pkg::KIND_STOP_RD: begin
        r.bus_response = ppe_pkg::RESP_COMPLETE;
      end
      default: begin
        r.bus_response = ppe_pkg::RESP_NONE;
      end
    endcase
    return r;
  endfunction

  // one event transfer; valid stays up afterwards so back-to-back events need no gap
  task automatic send_event(input logic [2:0] kind, input logic [7:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= data;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_responses.push_back(bus_event_response(kind, data));
    events_sent++;
  endtask

  task automatic test_bus_events();
    send_event(ppe_pkg::KIND_WR_START, 8'hFF);
    send_event(ppe_pkg::KIND_RX_BYTE, ppe_pkg::CMD_NONE);  // zero byte leaves the command open
    send_event(ppe_pkg::KIND_RX_BYTE, ppe_pkg::CMD_APPEND);
    send_event(ppe_pkg::KIND_RX_BYTE, 8'hFF);
    send_event(ppe_pkg::KIND_RX_BYTE, 8'h00);
    send_event(ppe_pkg::KIND_RX_BYTE, 8'h5A);
    send_event(ppe_pkg::KIND_STOP_WR, 8'h00);
    send_event(ppe_pkg::KIND_WR_START, 8'h00);
    send_event(ppe_pkg::KIND_RX_BYTE, ppe_pkg::CMD_REWIND);
    send_event(ppe_pkg::KIND_STOP_WR, 8'hAA);
    send_event(ppe_pkg::KIND_RD_START, 8'h55);
    send_event(ppe_pkg::KIND_TX_REQ, 8'hFF);
    send_event(ppe_pkg::KIND_TX_REQ, 8'h00);
    send_event(ppe_pkg::KIND_STOP_RD, 8'h0F);
    send_event(KIND_ERROR, 8'hC3);
    send_event(KIND_UNUSED, 8'h3C);
  endtask

  task automatic test_page_commands();
    send_event(ppe_pkg::KIND_WR_START, 8'h00);
    send_event(ppe_pkg::KIND_RX_BYTE, ppe_pkg::CMD_PROGRAM);
    send_event(ppe_pkg::KIND_RX_BYTE, 8'hFF);
    send_event(ppe_pkg::KIND_STOP_WR, 8'h00);
    send_event(ppe_pkg::KIND_STOP_WR, 8'h00);        // repeats the program
    send_event(ppe_pkg::KIND_WR_START, 8'h00);
    send_event(ppe_pkg::KIND_RX_BYTE, ppe_pkg::CMD_FETCH);
    send_event(ppe_pkg::KIND_RX_BYTE, 8'h07);        // still erased
    send_event(ppe_pkg::KIND_STOP_WR, 8'h00);
    send_event(ppe_pkg::KIND_WR_START, 8'h00);
    send_event(ppe_pkg::KIND_RX_BYTE, ppe_pkg::CMD_RESTART);
    send_event(ppe_pkg::KIND_STOP_WR, 8'h00);
    send_event(ppe_pkg::KIND_WR_START, 8'h00);
    send_event(ppe_pkg::KIND_RX_BYTE, 8'hFF);        // unknown command
    send_event(ppe_pkg::KIND_RX_BYTE, 8'h12);
    send_event(ppe_pkg::KIND_STOP_WR, 8'h00);
  endtask

  task automatic test_index_wrap();
    send_event(ppe_pkg::KIND_WR_START, 8'h00);
    send_event(ppe_pkg::KIND_RX_BYTE, ppe_pkg::CMD_APPEND);
    repeat (PAGE_BYTES + 6) send_event(ppe_pkg::KIND_RX_BYTE, 8'($urandom));
    send_event(ppe_pkg::KIND_STOP_WR, 8'h00);
    send_event(ppe_pkg::KIND_RD_START, 8'h00);
    repeat (PAGE_BYTES + 2) send_event(ppe_pkg::KIND_TX_REQ, 8'($urandom));
    send_event(ppe_pkg::KIND_STOP_RD, 8'h00);
  endtask

  // mostly well-formed transactions with random content, some noise
  task automatic random_transaction();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  page_arg;
    logic [7:0]  cmd;
    pick = $urandom_range(0, 99);
    page_arg = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                           : favorite_pages[$urandom_range(0, 3)];
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
    if (pick < 30) begin
      send_event(ppe_pkg::KIND_WR_START, 8'($urandom));
      send_event(ppe_pkg::KIND_RX_BYTE, ppe_pkg::CMD_APPEND);
      repeat (n) send_event(ppe_pkg::KIND_RX_BYTE, 8'($urandom));
      send_event(ppe_pkg::KIND_STOP_WR, 8'($urandom));
    end else if (pick < 48) begin
      case ($urandom_range(0, 2))
        0: cmd = ppe_pkg::CMD_PROGRAM;
        1: cmd = ppe_pkg::CMD_FETCH;
        default: cmd = ppe_pkg::CMD_REWIND;
      endcase
      send_event(ppe_pkg::KIND_WR_START, 8'($urandom));
      send_event(ppe_pkg::KIND_RX_BYTE, cmd);
      send_event(ppe_pkg::KIND_RX_BYTE, page_arg);
      send_event(ppe_pkg::KIND_STOP_WR, 8'($urandom));
      if ($urandom_range(0, 4) == 0) send_event(ppe_pkg::KIND_STOP_WR, 8'($urandom));
    end else if (pick < 68) begin
      send_event(ppe_pkg::KIND_RD_START, 8'($urandom));
      repeat (n) send_event(ppe_pkg::KIND_TX_REQ, 8'($urandom));
      send_event(ppe_pkg::KIND_STOP_RD, 8'($urandom));
    end else if (pick < 73) begin
      send_event(ppe_pkg::KIND_WR_START, 8'($urandom));
      send_event(ppe_pkg::KIND_RX_BYTE, ppe_pkg::CMD_RESTART);
      send_event(ppe_pkg::KIND_STOP_WR, 8'($urandom));
    end else if (pick < 82) begin
      send_event(ppe_pkg::KIND_WR_START, 8'($urandom));
      repeat ($urandom_range(1, 3)) send_event(ppe_pkg::KIND_RX_BYTE, 8'($urandom));
      send_event(ppe_pkg::KIND_STOP_WR, 8'($urandom));
    end else begin
      send_event(3'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_random_events(input int unsigned count);
    int unsigned target;
    target = events_sent + count;
    while (events_sent < target) random_transaction();
  endtask

  // response side: random stalls and comparison against the oldest expectation
  always @(posedge clk_i) begin
    ppe_pkg::ppe_res_t got;
    ppe_pkg::ppe_res_t exp;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.tx_byte       = m_axis_tdata_o[7:0];
        got.bus_response  = m_axis_tdata_o[9:8];
        got.reset_request = m_axis_tdata_o[10];
        got.tx_valid      = m_axis_tuser_o[0];
        responses_seen++;
        if (expected_responses.size() == 0) begin
          unexpected++;
          if (mismatches + unexpected <= 10)
            $display("unexpected response: tx_byte=%h tx_valid=%b resp=%0d rst_req=%b",
                     got.tx_byte, got.tx_valid, got.bus_response, got.reset_request);
        end else begin
          exp = expected_responses.pop_front();
          if (got.tx_byte !== exp.tx_byte || got.tx_valid !== exp.tx_valid ||
              got.bus_response !== exp.bus_response ||
              got.reset_request !== exp.reset_request) begin
            mismatches++;
            if (mismatches + unexpected <= 10) begin
              $write("response %0d: exp tx_byte=%h tx_valid=%b resp=%0d rst_req=%b,",
                     responses_seen, exp.tx_byte, exp.tx_valid, exp.bus_response,
                     exp.reset_request);
              $display(" got tx_byte=%h tx_valid=%b resp=%0d rst_req=%b",
                       got.tx_byte, got.tx_valid, got.bus_response, got.reset_request);
            end
          end
        end
      end
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("i2c_page_programming_engine_core_test NOT OK");
    $finish;
  end

  initial begin
    cmd_model = ppe_pkg::CMD_NONE;
    arg_model = 8'h00;
    buf_pos = 0;
    for (int i = 0; i < PAGE_BYTES; i++) page_model[i] = 8'h00;
    for (int i = 0; i < PAGE_BYTES*PAGE_COUNT; i++) flash_model[i] = ppe_pkg::ERASED_BYTE;
    events_sent = 0;
    responses_seen = 0;
    mismatches = 0;
    unexpected = 0;
    pages_programmed = 0;
    pages_fetched = 0;
    bytes_read = 0;
    send_idle_pct = 36;
    recv_stall_pct = 46;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_bus_events();
    test_page_commands();
    test_random_events(125);

    send_idle_pct = 46;
    recv_stall_pct = 36;
    test_index_wrap();
    test_random_events(125);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_events(125);

    s_axis_tvalid_i <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("%0d bus events sent, %0d responses checked, %0d bytes read back",
             events_sent, responses_seen, bytes_read);
    $display("%0d page programs and %0d page fetches carried out",
             pages_programmed, pages_fetched);
    if (mismatches == 0 && unexpected == 0 && expected_responses.size() == 0) begin
      $display("i2c_page_programming_engine_core_test OK");
    end else begin
      $display("i2c_page_programming_engine_core_test NOT OK");
    end
    $finish;
  end

endmodule
